>>> sv/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared codes, character constants and controller/datapath interface types
// for the calculator token scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

   // token kinds
   localparam logic [2:0] KIND_IDCHAR   = 3'd0;
   localparam logic [2:0] KIND_OP       = 3'd1;
   localparam logic [2:0] KIND_INT      = 3'd2;
   localparam logic [2:0] KIND_EXPR_END = 3'd3;
   localparam logic [2:0] KIND_FILE_END = 3'd4;
   localparam logic [2:0] KIND_ERROR    = 3'd5;

   // operator codes
   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_SUB    = 3'd1;
   localparam logic [2:0] OP_MUL    = 3'd2;
   localparam logic [2:0] OP_DIV    = 3'd3;
   localparam logic [2:0] OP_ASSIGN = 3'd4;
   localparam logic [2:0] OP_OPEN   = 3'd5;
   localparam logic [2:0] OP_CLOSE  = 3'd6;

   // scan modes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_IDENT = 2'd1;
   localparam logic [1:0] MODE_INT   = 2'd2;

   // what a byte does when scanned from start mode
   localparam logic [1:0] ACT_SKIP  = 2'd0;
   localparam logic [1:0] ACT_IDENT = 2'd1;
   localparam logic [1:0] ACT_INT   = 2'd2;
   localparam logic [1:0] ACT_TOKEN = 2'd3;

   // characters
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_ONE        = 8'h31;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

   localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] mode;
      logic       eof;
      logic       id_cont;     // lowercase, digit or underscore
      logic       digit;
      logic       len_full;
      logic       id_last;     // read pointer on final buffered char
      logic [1:0] start_act;
      logic [2:0] tok_kind;
      logic [2:0] tok_op;
      logic       slot_free;   // output register can take a result
   } cts_status_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;
      logic       buf_wr;
      logic       len_clear;
      logic       acc_mac;
      logic       acc_clear;
      logic       mode_wr;
      logic [1:0] mode_val;
      logic       idx_clear;
      logic       idx_inc;
      logic       out_load;
      logic [2:0] out_kind;
      logic [2:0] out_op;
      logic       out_last;
   } cts_cmd_type;

endpackage

>>> sv/calculator_token_scanner_unit.sv
// ----------------------------------------------------------------------------
// calculator_token_scanner_unit
// Byte-serial lexer for calculator expressions: identifiers, integers,
// operators, newline and end of file become result tokens.
// ----------------------------------------------------------------------------
// Usage:
//   One request carries one text byte (req_char_code) or an end-of-file
//   marker (req_end_of_file). Each request yields zero or more results on
//   the rsp_ channel; rsp_last flags the final result of a request.
//   An identifier is held in an internal buffer and replayed as one
//   identifier-char result per character when its terminating byte arrives.
// Sequence:
//   A request that only extends a token is accepted, then decided.
//   A request that closes an identifier is accepted and decided, then its N
//   buffered characters are replayed, one per cycle while the output register
//   is free, from the buffer memory's read port, then the terminating byte is rescanned.
//   Closing an integer likewise adds a rescan of the terminating byte. Each
//   result is loaded into the output register as it is decided.
// Reset: scanner returns to start mode, buffer length and accumulator clear,
//   no result pending. Buffer contents are not cleared.
// Stall: results wait in the output register; a step that must load a result
//   holds in place until that register frees, and no request is accepted meanwhile.
// ----------------------------------------------------------------------------
module calculator_token_scanner_unit #(
   parameter int MAX_IDENT_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token_kind,
   output logic [2:0]  rsp_operator_code,
   output logic [30:0] rsp_int_value,
   output logic [7:0]  rsp_id_char,
   output logic [4:0]  rsp_id_position,
   output logic        rsp_last
);
   import cts_pkg::*;

   cts_cmd_type    cmd;     // sequencer commands
   cts_status_type status;  // classes, buffer flags, output slot

   // sequencer: idle -> decide -> (identifier replay -> decide) -> idle
   cts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath with identifier buffer and output register
   cts_dp #(
      .MAX_IDENT_LEN (MAX_IDENT_LEN)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_char_code     (req_char_code),
      .req_end_of_file   (req_end_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_operator_code (rsp_operator_code),
      .rsp_int_value     (rsp_int_value),
      .rsp_id_char       (rsp_id_char),
      .rsp_id_position   (rsp_id_position),
      .rsp_last          (rsp_last)
   );

endmodule

>>> sv/cts_ctrl.sv
// ----------------------------------------------------------------------------
// cts_ctrl
// Scanner sequencer: takes a request, decides per mode, and paces the
// identifier replay and token results against the output register.
// ----------------------------------------------------------------------------
module cts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cts_pkg::cts_status_type status,
   output cts_pkg::cts_cmd_type    cmd
);
   import cts_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_DECIDE  = 2'd1;
   localparam logic [1:0] ST_EMIT_ID = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       start_silent;

   // start scan of the held byte gives no result of its own
   assign start_silent = !status.eof && (status.start_act != ACT_TOKEN);

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.mode_val = MODE_START;
      cmd.out_kind = KIND_ERROR;
      cmd.out_op   = OP_ADD;
      state_in     = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.mode == MODE_IDENT) begin
               if (!status.eof && status.id_cont) begin
                  if (!status.len_full) begin
                     cmd.buf_wr = 1'b1;
                     state_in   = ST_IDLE;
                  end else if (status.slot_free) begin
                     cmd.out_load  = 1'b1;
                     cmd.out_kind  = KIND_ERROR;
                     cmd.out_last  = 1'b1;
                     cmd.len_clear = 1'b1;
                     cmd.mode_wr   = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end else begin
                  cmd.idx_clear = 1'b1;
                  state_in      = ST_EMIT_ID;
               end
            end else if (status.mode == MODE_INT) begin
               if (!status.eof && status.digit) begin
                  cmd.acc_mac = 1'b1;
                  state_in    = ST_IDLE;
               end else if (status.slot_free) begin
                  // integer out, then rescan the byte in start mode
                  cmd.out_load  = 1'b1;
                  cmd.out_kind  = KIND_INT;
                  cmd.out_last  = start_silent;
                  cmd.acc_clear = 1'b1;
                  cmd.mode_wr   = 1'b1;
               end
            end else begin
               case (status.start_act)
                  ACT_SKIP: begin
                     cmd.mode_wr = 1'b1;
                     state_in    = ST_IDLE;
                  end
                  ACT_IDENT: begin
                     cmd.buf_wr   = 1'b1;
                     cmd.mode_wr  = 1'b1;
                     cmd.mode_val = MODE_IDENT;
                     state_in     = ST_IDLE;
                  end
                  ACT_INT: begin
                     cmd.acc_mac  = 1'b1;
                     cmd.mode_wr  = 1'b1;
                     cmd.mode_val = MODE_INT;
                     state_in     = ST_IDLE;
                  end
                  default: begin
                     if (status.slot_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = status.tok_kind;
                        cmd.out_op   = status.tok_op;
                        cmd.out_last = 1'b1;
                        cmd.mode_wr  = 1'b1;
                        state_in     = ST_IDLE;
                     end
                  end
               endcase
            end
         end
         ST_EMIT_ID: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_IDCHAR;
               cmd.out_last = status.id_last && start_silent;
               cmd.idx_inc  = 1'b1;
               if (status.id_last) begin
                  cmd.len_clear = 1'b1;
                  cmd.mode_wr   = 1'b1;
                  state_in      = ST_DECIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/cts_dp.sv
// ----------------------------------------------------------------------------
// cts_dp
// Scanner datapath: held input byte, character classes, identifier buffer,
// saturating decimal accumulator and the result output register.
// ----------------------------------------------------------------------------
module cts_dp #(
   parameter int MAX_IDENT_LEN = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cts_pkg::cts_cmd_type    cmd,
   output cts_pkg::cts_status_type status,
   input  logic [7:0]              req_char_code,
   input  logic                    req_end_of_file,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_token_kind,
   output logic [2:0]              rsp_operator_code,
   output logic [30:0]             rsp_int_value,
   output logic [7:0]              rsp_id_char,
   output logic [4:0]              rsp_id_position,
   output logic                    rsp_last
);
   import cts_pkg::*;

   localparam int LEN_W  = $clog2(MAX_IDENT_LEN + 1);
   localparam int ADDR_W = (MAX_IDENT_LEN > 1) ? $clog2(MAX_IDENT_LEN) : 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_IDENT_LEN);

   logic [7:0]        char_ff;
   logic              eof_ff;
   logic [1:0]        mode_ff;
   logic [1:0]        mode_in;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic [30:0]       acc_ff;
   logic [30:0]       acc_in;
   logic [LEN_W-1:0]  idx_ff;
   logic [LEN_W-1:0]  idx_in;
   logic [7:0]        rd_data_ff;
   logic [7:0]        ident_mem [0:MAX_IDENT_LEN-1];

   logic              rsp_valid_ff;
   logic [2:0]        kind_ff;
   logic [2:0]        op_ff;
   logic [30:0]       int_ff;
   logic [7:0]        id_char_ff;
   logic [4:0]        pos_ff;
   logic              last_ff;

   logic              is_lower;
   logic              is_digit;
   logic [1:0]        start_act;
   logic [2:0]        tok_kind;
   logic [2:0]        tok_op;
   logic [34:0]       mac_sum;
   logic              slot_free;

   // ---- classification of the held byte ----
   assign is_lower = (char_ff inside {[CH_LOWER_A:CH_LOWER_Z]});
   assign is_digit = (char_ff inside {[CH_ZERO:CH_NINE]});

   always_comb begin
      start_act = ACT_TOKEN;
      tok_kind  = KIND_ERROR;
      tok_op    = OP_ADD;
      if (eof_ff) begin
         tok_kind = KIND_FILE_END;
      end else if (char_ff == CH_SPACE || char_ff == CH_TAB) begin
         start_act = ACT_SKIP;
      end else if (is_lower) begin
         start_act = ACT_IDENT;
      end else if (char_ff inside {[CH_ONE:CH_NINE]}) begin
         start_act = ACT_INT;
      end else begin
         case (char_ff)
            CH_PLUS: begin
               tok_kind = KIND_OP;
               tok_op   = OP_ADD;
            end
            CH_MINUS: begin
               tok_kind = KIND_OP;
               tok_op   = OP_SUB;
            end
            CH_STAR: begin
               tok_kind = KIND_OP;
               tok_op   = OP_MUL;
            end
            CH_SLASH: begin
               tok_kind = KIND_OP;
               tok_op   = OP_DIV;
            end
            CH_EQUAL: begin
               tok_kind = KIND_OP;
               tok_op   = OP_ASSIGN;
            end
            CH_LPAREN: begin
               tok_kind = KIND_OP;
               tok_op   = OP_OPEN;
            end
            CH_RPAREN: begin
               tok_kind = KIND_OP;
               tok_op   = OP_CLOSE;
            end
            CH_NEWLINE: begin
               tok_kind = KIND_EXPR_END;
            end
            default: begin
               tok_kind = KIND_ERROR;
            end
         endcase
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status           = '0;
      status.mode      = mode_ff;
      status.eof       = eof_ff;
      status.id_cont   = is_lower || is_digit || (char_ff == CH_UNDERSCORE);
      status.digit     = is_digit;
      status.len_full  = (len_ff == LEN_MAX);
      status.id_last   = (idx_ff == len_ff - LEN_W'(1));
      status.start_act = start_act;
      status.tok_kind  = tok_kind;
      status.tok_op    = tok_op;
      status.slot_free = slot_free;
   end

   // ---- accumulator: acc*10 + digit, saturating ----
   assign mac_sum = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                  + {31'd0, char_ff[3:0] - CH_ZERO[3:0]};

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (cmd.acc_mac) begin
         acc_in = (mac_sum > {4'd0, INT_SAT}) ? INT_SAT : mac_sum[30:0];
      end
   end

   always_comb begin
      len_in = len_ff;
      if (cmd.len_clear) begin
         len_in = '0;
      end else if (cmd.buf_wr) begin
         len_in = len_ff + LEN_W'(1);
      end
   end

   assign mode_in = cmd.mode_wr ? cmd.mode_val : mode_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
         len_ff  <= '0;
         acc_ff  <= '0;
         idx_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         char_ff <= req_char_code;
         eof_ff  <= req_end_of_file;
      end
   end

   // ---- identifier buffer; read data tracks the replay pointer ----
   always_ff @(posedge clock) begin
      if (cmd.buf_wr) begin
         ident_mem[len_ff[ADDR_W-1:0]] <= char_ff;
      end
      if (idx_in < LEN_MAX) begin
         rd_data_ff <= ident_mem[idx_in[ADDR_W-1:0]];
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         kind_ff    <= cmd.out_kind;
         op_ff      <= cmd.out_op;
         int_ff     <= (cmd.out_kind == KIND_INT) ? acc_ff : '0;
         id_char_ff <= (cmd.out_kind == KIND_IDCHAR) ? rd_data_ff : '0;
         pos_ff     <= (cmd.out_kind == KIND_IDCHAR) ? 5'(idx_ff) : '0;
         last_ff    <= cmd.out_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_token_kind    = kind_ff;
   assign rsp_operator_code = op_ff;
   assign rsp_int_value     = int_ff;
   assign rsp_id_char       = id_char_ff;
   assign rsp_id_position   = pos_ff;
   assign rsp_last          = last_ff;

`ifndef NO_ASSERTIONS
   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_MAX)
      else $error("identifier length beyond buffer");

   a_ident_nonempty: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDENT) |-> (len_ff != '0))
      else $error("identifier mode with empty buffer");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_START) |-> (len_ff == '0 && acc_ff == '0))
      else $error("start mode with stale identifier or integer");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for calculator_token_scanner_unit: random and directed
// expression text is sent byte by byte, an in-bench scanner predicts the
// token stream, and every result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
   import cts_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int ID_MAX       = 32;     // identifier buffer depth of the DUT
   localparam int RANDOM_ITEMS = 200;    // non-blank random requests
   localparam int DRAIN_CYCLES = 64;     // > longest identifier replay
   localparam int IDLE_LIMIT   = 2000;   // cycles with no handshake at all

   // shapes of generated text
   typedef enum int {
      SHAPE_IDENT, SHAPE_INT, SHAPE_OP, SHAPE_BLANK, SHAPE_NOISE, SHAPE_EOF,
      SHAPE_FULL_IDENT, SHAPE_LONG_IDENT, SHAPE_BIG_INT
   } text_shape_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eof;
      logic       hold;   // wait for all tokens before sending this byte
   } text_byte_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  op;
      logic [30:0] value;
      logic [7:0]  ch;
      logic [4:0]  pos;
      logic        is_last;
   } token_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = '0;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [2:0]  rsp_operator_code;
   logic [30:0] rsp_int_value;
   logic [7:0]  rsp_id_char;
   logic [4:0]  rsp_id_position;
   logic        rsp_last;

   // text waiting to be sent, tokens still owed by the DUT
   text_byte_type text_q[$];
   token_type     tokens_due[$];

   // in-bench scanner state
   logic [1:0]  scan_mode   = MODE_START;
   logic [7:0]  name_buf[ID_MAX];
   int          name_len    = 0;
   logic [30:0] number_acc  = '0;

   // driver / monitor bookkeeping
   int            send_gap = 0, send_calm = 0;
   int            take_stall = 0, take_calm = 0;
   bit            drain_wait = 0;
   bit            all_tokens_in = 1;
   text_byte_type held_byte, next_byte;
   bit            hold_next = 0;
   int            planned_items = 0;
   int            requests_done = 0, tokens_checked = 0, bad_tokens = 0;
   int            kind_seen[8];
   int            idle_cycles = 0;
   token_type     got, want;

   calculator_token_scanner_unit #(
      .MAX_IDENT_LEN(ID_MAX)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_operator_code(rsp_operator_code),
      .rsp_int_value    (rsp_int_value),
      .rsp_id_char      (rsp_id_char),
      .rsp_id_position  (rsp_id_position),
      .rsp_last         (rsp_last)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------------
   // Token prediction
   // ------------------------------------------------------------------------

   // Append one expected token; other fields stay zero as the DUT drives them.
   function automatic void owe_token(logic [2:0] kind, logic [2:0] op,
                                     logic [30:0] value, logic [7:0] ch,
                                     logic [4:0] pos);
      token_type t;
      t = '{kind: kind, op: op, value: value, ch: ch, pos: pos, is_last: 1'b0};
      tokens_due.push_back(t);
   endfunction

   // Scan a byte as if no token were open. At most one token.
   function automatic void scan_fresh(logic [7:0] ch, logic eof);
      scan_mode = MODE_START;
      if (eof) begin
         owe_token(KIND_FILE_END, OP_ADD, '0, '0, '0);
      end else if (ch == CH_SPACE || ch == CH_TAB) begin
         // blanks give nothing
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
         name_buf[0] = ch;
         name_len    = 1;
         scan_mode   = MODE_IDENT;
      end else if (ch >= CH_ONE && ch <= CH_NINE) begin
         number_acc = 31'(ch - CH_ZERO);
         scan_mode  = MODE_INT;
      end else begin
         case (ch)
            CH_PLUS:    owe_token(KIND_OP, OP_ADD, '0, '0, '0);
            CH_MINUS:   owe_token(KIND_OP, OP_SUB, '0, '0, '0);
            CH_STAR:    owe_token(KIND_OP, OP_MUL, '0, '0, '0);
            CH_SLASH:   owe_token(KIND_OP, OP_DIV, '0, '0, '0);
            CH_EQUAL:   owe_token(KIND_OP, OP_ASSIGN, '0, '0, '0);
            CH_LPAREN:  owe_token(KIND_OP, OP_OPEN, '0, '0, '0);
            CH_RPAREN:  owe_token(KIND_OP, OP_CLOSE, '0, '0, '0);
            CH_NEWLINE: owe_token(KIND_EXPR_END, OP_ADD, '0, '0, '0);
            // includes a leading zero
            default:    owe_token(KIND_ERROR, OP_ADD, '0, '0, '0);
         endcase
      end
   endfunction

   // Full effect of one accepted request: queue its tokens, flag the last.
   function automatic void scan_request(logic [7:0] ch, logic eof);
      int          owed_before;
      logic [63:0] wide;
      token_type   t;
      owed_before = tokens_due.size();
      if (scan_mode == MODE_IDENT) begin
         if (!eof && ((ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ||
                      (ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_UNDERSCORE)) begin
            if (name_len < ID_MAX) begin
               name_buf[name_len] = ch;
               name_len++;
            end else begin
               // over-long name: dropped along with this byte
               name_len  = 0;
               scan_mode = MODE_START;
               owe_token(KIND_ERROR, OP_ADD, '0, '0, '0);
            end
         end else begin
            for (int i = 0; i < name_len; i++)
               owe_token(KIND_IDCHAR, OP_ADD, '0, name_buf[i], 5'(i));
            name_len = 0;
            scan_fresh(ch, eof);
         end
      end else if (scan_mode == MODE_INT) begin
         if (!eof && ch >= CH_ZERO && ch <= CH_NINE) begin
            wide = 64'(number_acc) * 64'd10 + 64'(ch - CH_ZERO);
            number_acc = (wide > 64'(INT_SAT)) ? INT_SAT : wide[30:0];
         end else begin
            owe_token(KIND_INT, OP_ADD, number_acc, '0, '0);
            number_acc = '0;
            scan_fresh(ch, eof);
         end
      end else begin
         scan_fresh(ch, eof);
      end
      if (tokens_due.size() > owed_before) begin
         t = tokens_due.pop_back();
         t.is_last = 1'b1;
         tokens_due.push_back(t);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Mostly back-to-back, sometimes short gaps, rarely long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] op_char(int idx);
      case (idx)
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         3:       return CH_SLASH;
         4:       return CH_EQUAL;
         5:       return CH_LPAREN;
         default: return CH_RPAREN;
      endcase
   endfunction

   // Blank bytes are not counted: in start mode they do nothing.
   task automatic push_byte(input logic [7:0] ch, input logic eof = 1'b0);
      text_q.push_back('{ch: ch, eof: eof, hold: hold_next});
      hold_next = 0;
      if (eof || (ch != CH_SPACE && ch != CH_TAB))
         planned_items++;
   endtask

   task automatic push_eof();
      push_byte(8'($urandom_range(0, 255)), 1'b1);   // char is don't-care
   endtask

   // Byte that closes an open identifier or integer.
   task automatic push_closer();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) push_byte(CH_SPACE);
      else if (r < 3) push_byte(CH_TAB);
      else if (r < 6) push_byte(op_char($urandom_range(0, 6)));
      else if (r < 7) push_byte(CH_NEWLINE);
      else if (r < 8) push_eof();
      else push_byte(8'($urandom_range(0, 255)));    // may also extend it
   endtask

   // ------------------------------------------------------------------------
   // Driver: one request in flight, random gaps after each accept. A byte
   // flagged hold is kept back until every owed token has been taken.
   // ------------------------------------------------------------------------
   task automatic drive_byte(input text_byte_type b);
      req_valid       <= 1'b1;
      req_char_code   <= b.ch;
      req_end_of_file <= b.eof;
      if (send_calm > 0) begin
         send_calm--;
         send_gap = 0;
      end else begin
         send_gap = pick_gap();
         if ($urandom_range(0, 39) == 0)
            send_calm = $urandom_range(20, 80);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         scan_mode  = MODE_START;
         name_len   = 0;
         number_acc = '0;
      end else begin
         if (req_valid && req_ready) begin
            scan_request(req_char_code, req_end_of_file);
            requests_done++;
         end
         // only move on once the current request is gone
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (drain_wait) begin
               if (all_tokens_in) begin
                  drain_wait = 0;
                  drive_byte(held_byte);
               end else begin
                  req_valid <= 1'b0;
               end
            end else if (text_q.size() != 0) begin
               next_byte = text_q.pop_front();
               if (next_byte.hold) begin
                  // wait instead of sending now, so tokens owed by this edge's accept are counted
                  held_byte  = next_byte;
                  drain_wait = 1;
                  req_valid <= 1'b0;
               end else begin
                  drive_byte(next_byte);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Sampled away from the rising edge so the driver sees a settled count.
   always @(negedge clock)
      all_tokens_in = (tokens_due.size() == 0);

   // ------------------------------------------------------------------------
   // Monitor: random back-pressure, in-order compare against owed tokens.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_token_kind, rsp_operator_code, rsp_int_value,
                   rsp_id_char, rsp_id_position, rsp_last};
            kind_seen[rsp_token_kind]++;
            tokens_checked++;
            if (tokens_due.size() == 0) begin
               if (bad_tokens < 10)
                  $display("%0t: token with none owed: kind %0d op %0d value %0d char %02h",
                           $time, got.kind, got.op, got.value, got.ch);
               bad_tokens++;
            end else begin
               want = tokens_due.pop_front();
               if (got !== want) begin
                  if (bad_tokens < 10)
                     $display({"%0t: token mismatch (exp/act): kind %0d/%0d op %0d/%0d ",
                               "value %0d/%0d char %02h/%02h pos %0d/%0d last %0d/%0d"},
                              $time, want.kind, got.kind, want.op, got.op,
                              want.value, got.value, want.ch, got.ch,
                              want.pos, got.pos, want.is_last, got.is_last);
                  bad_tokens++;
               end
            end
         end
         if (take_stall > 0) begin
            take_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (take_calm > 0) begin
               take_calm--;
            end else begin
               take_stall = pick_gap();
               if ($urandom_range(0, 39) == 0)
                  take_calm = $urandom_range(20, 80);
            end
         end
      end
   end

   // Watchdog: a stuck handshake on either side ends the run.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or token moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Text generation and end of run
   // ------------------------------------------------------------------------
   initial begin
      int             seq_no, n, r;
      text_shape_type shape;

      // directed: name with both letter ends plus '_', digits, then "109+",
      // every operator, newline, tab, leading zero, bytes that start nothing,
      // end of file inside a name, inside a number, and twice in a row
      push_byte(CH_LOWER_A);
      push_byte(CH_LOWER_Z);
      push_byte(CH_UNDERSCORE);
      push_byte(CH_ZERO);
      push_byte(CH_NINE);
      push_byte(CH_SPACE);
      push_byte(CH_ONE);
      push_byte(CH_ZERO);
      push_byte(CH_NINE);
      for (int i = 0; i < 7; i++)
         push_byte(op_char(i));
      push_byte(CH_NEWLINE);
      push_byte(CH_TAB);
      push_byte(CH_ZERO);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(CH_LOWER_Z);
      push_eof();
      push_byte(CH_NINE);
      push_eof();
      push_eof();

      // random: mostly well-formed tokens with random content; the first
      // few force a full buffer, a too-long name and a saturating number
      planned_items = 0;
      seq_no = 0;
      while (planned_items < RANDOM_ITEMS) begin
         hold_next = (seq_no == 3) || ($urandom_range(0, 24) == 0);
         r = $urandom_range(0, 99);
         if (seq_no == 0) shape = SHAPE_FULL_IDENT;
         else if (seq_no == 1) shape = SHAPE_LONG_IDENT;
         else if (seq_no == 2) shape = SHAPE_BIG_INT;
         else if (r < 30) shape = SHAPE_IDENT;
         else if (r < 55) shape = SHAPE_INT;
         else if (r < 70) shape = SHAPE_OP;
         else if (r < 77) shape = SHAPE_BLANK;
         else if (r < 87) shape = SHAPE_NOISE;
         else if (r < 92) shape = SHAPE_EOF;
         else if (r < 95) shape = SHAPE_FULL_IDENT;
         else if (r < 97) shape = SHAPE_LONG_IDENT;
         else shape = SHAPE_BIG_INT;

         case (shape)
            SHAPE_IDENT, SHAPE_FULL_IDENT, SHAPE_LONG_IDENT: begin
               if (shape == SHAPE_FULL_IDENT) n = ID_MAX;
               else if (shape == SHAPE_LONG_IDENT) n = $urandom_range(ID_MAX + 1, ID_MAX + 4);
               else n = $urandom_range(1, 8);
               push_byte(CH_LOWER_A + 8'($urandom_range(0, 25)));
               repeat (n - 1) begin
                  r = $urandom_range(0, 36);
                  if (r < 26) push_byte(CH_LOWER_A + 8'(r));
                  else if (r < 36) push_byte(CH_ZERO + 8'(r - 26));
                  else push_byte(CH_UNDERSCORE);
               end
               push_closer();
            end
            SHAPE_INT, SHAPE_BIG_INT: begin
               n = (shape == SHAPE_BIG_INT) ? $urandom_range(11, 13) : $urandom_range(1, 6);
               push_byte(CH_ONE + 8'($urandom_range(0, 8)));
               repeat (n - 1)
                  push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
               push_closer();
            end
            SHAPE_OP: begin
               if ($urandom_range(0, 7) == 0) push_byte(CH_NEWLINE);
               else push_byte(op_char($urandom_range(0, 6)));
            end
            SHAPE_BLANK: push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            SHAPE_NOISE: push_byte(8'($urandom_range(0, 255)));
            default:     push_eof();
         endcase
         seq_no++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // all text sent and every owed token back, then let the pipe settle
      do @(negedge clock);
      while (text_q.size() != 0 || drain_wait || req_valid || tokens_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("scanner run: %0d requests sent, %0d tokens checked, %0d mismatches",
               requests_done, tokens_checked, bad_tokens);
      $display({"token mix: %0d name chars, %0d operators, %0d integers, ",
                "%0d newlines, %0d end-of-file, %0d errors"},
               kind_seen[KIND_IDCHAR], kind_seen[KIND_OP], kind_seen[KIND_INT],
               kind_seen[KIND_EXPR_END], kind_seen[KIND_FILE_END], kind_seen[KIND_ERROR]);
      if (bad_tokens == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
